### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the polyline guard design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PSIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define PSIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/psig_pkg.sv
// ----------------------------------------------------------------------------
// psig_pkg
// Types and constants shared by the polyline self-intersection guard.
// ----------------------------------------------------------------------------
package psig_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int VTX_W       = 16;
  localparam int CFG_W       = 15;
  localparam int CFG_AW      = 2;
  localparam int TOL_W       = 8;
  localparam int VCNT_W      = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_VIEW_W = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_VIEW_H = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TOL_X  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_TOL_Y  = 2'd3;

  localparam logic [CFG_W-1:0] VIEW_W_RST = 15'd1024;
  localparam logic [CFG_W-1:0] VIEW_H_RST = 15'd768;
  localparam logic [TOL_W-1:0] TOL_RST    = 8'd5;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // x in the low half, y in the high half
  typedef struct packed {
    logic signed [VTX_W-1:0] y;
    logic signed [VTX_W-1:0] x;
  } vtx_t;

  typedef struct packed {
    logic vld;
    vtx_t a;
    vtx_t b;
  } edge_req_t;

  typedef struct packed {
    logic busy;
    logic vld;
    logic hit;
  } edge_res_t;

endpackage

### design/psig_edge.sv
// ----------------------------------------------------------------------------
// psig_edge
// Three-stage pipelined segment intersection test with integer cross products.
// ----------------------------------------------------------------------------
module psig_edge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psig_pkg::edge_req_t  req,   // stored edge A-B
  input  psig_pkg::vtx_t       pt,    // new point C
  input  psig_pkg::vtx_t       lst,   // last vertex D
  output psig_pkg::edge_res_t  res
);
  import psig_pkg::*;

  localparam int DW = VTX_W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [VTX_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [VTX_W-1:0] p0, p1, q0, q1, lo, hi;
  logic use_x, ovl, share;

  logic                  s1_vld_r;
  logic signed [DW-1:0]  s1_bax_r, s1_bay_r, s1_cax_r, s1_cay_r, s1_dax_r, s1_day_r;
  logic signed [DW-1:0]  s1_dcx_r, s1_dcy_r, s1_acx_r, s1_acy_r, s1_bcx_r, s1_bcy_r;
  logic                  s1_ovl_r, s1_share_r;

  logic                  s2_vld_r;
  logic signed [PW-1:0]  s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r;
  logic signed [PW-1:0]  s2_p5_r, s2_p6_r, s2_p7_r, s2_p8_r;
  logic                  s2_ovl_r, s2_share_r;

  logic                  s3_vld_r, s3_hit_r;

  logic signed [SW-1:0]  d1, d2, d3, d4;
  logic                  zero_all, str12, str34, hit;

  // stage 1: differences, shared-endpoint and collinear-overlap tests
  always_comb begin
    ax = req.a.x;  ay = req.a.y;
    bx = req.b.x;  by = req.b.y;
    cx = pt.x;     cy = pt.y;
    dx = lst.x;    dy = lst.y;
    use_x = (ax != bx) || (cx != dx);
    p0 = use_x ? ax : ay;
    p1 = use_x ? bx : by;
    q0 = use_x ? cx : cy;
    q1 = use_x ? dx : dy;
    lo = ((p0 < p1) ? p0 : p1) > ((q0 < q1) ? q0 : q1) ?
         ((p0 < p1) ? p0 : p1) : ((q0 < q1) ? q0 : q1);
    hi = ((p0 > p1) ? p0 : p1) < ((q0 > q1) ? q0 : q1) ?
         ((p0 > p1) ? p0 : p1) : ((q0 > q1) ? q0 : q1);
    ovl = lo < hi;
    share = (req.a == pt) || (req.a == lst) || (req.b == pt) || (req.b == lst);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_bax_r   <= DW'(bx) - DW'(ax);
    s1_bay_r   <= DW'(by) - DW'(ay);
    s1_cax_r   <= DW'(cx) - DW'(ax);
    s1_cay_r   <= DW'(cy) - DW'(ay);
    s1_dax_r   <= DW'(dx) - DW'(ax);
    s1_day_r   <= DW'(dy) - DW'(ay);
    s1_dcx_r   <= DW'(dx) - DW'(cx);
    s1_dcy_r   <= DW'(dy) - DW'(cy);
    s1_acx_r   <= DW'(ax) - DW'(cx);
    s1_acy_r   <= DW'(ay) - DW'(cy);
    s1_bcx_r   <= DW'(bx) - DW'(cx);
    s1_bcy_r   <= DW'(by) - DW'(cy);
    s1_ovl_r   <= ovl;
    s1_share_r <= share;

    // stage 2: eight independent products
    s2_p1_r    <= PW'(s1_bax_r) * PW'(s1_cay_r);
    s2_p2_r    <= PW'(s1_bay_r) * PW'(s1_cax_r);
    s2_p3_r    <= PW'(s1_bax_r) * PW'(s1_day_r);
    s2_p4_r    <= PW'(s1_bay_r) * PW'(s1_dax_r);
    s2_p5_r    <= PW'(s1_dcx_r) * PW'(s1_acy_r);
    s2_p6_r    <= PW'(s1_dcy_r) * PW'(s1_acx_r);
    s2_p7_r    <= PW'(s1_dcx_r) * PW'(s1_bcy_r);
    s2_p8_r    <= PW'(s1_dcy_r) * PW'(s1_bcx_r);
    s2_ovl_r   <= s1_ovl_r;
    s2_share_r <= s1_share_r;

    s3_hit_r   <= hit;
  end

  // stage 3: orientation signs and the verdict
  always_comb begin
    d1 = SW'(s2_p1_r) - SW'(s2_p2_r);
    d2 = SW'(s2_p3_r) - SW'(s2_p4_r);
    d3 = SW'(s2_p5_r) - SW'(s2_p6_r);
    d4 = SW'(s2_p7_r) - SW'(s2_p8_r);
    zero_all = (d1 == '0) && (d2 == '0) && (d3 == '0) && (d4 == '0);
    str12 = !(((d1 > 0) && (d2 > 0)) || ((d1 < 0) && (d2 < 0)));
    str34 = !(((d3 > 0) && (d4 > 0)) || ((d3 < 0) && (d4 < 0)));
    if (zero_all) begin
      hit = s2_ovl_r;
    end else if (s2_share_r) begin
      hit = 1'b0;
    end else begin
      hit = str12 && str34;
    end
  end

  assign res.busy = s1_vld_r || s2_vld_r || s3_vld_r;
  assign res.vld  = s3_vld_r;
  assign res.hit  = s3_hit_r;

endmodule

### design/polyline_self_intersection_guard_top.sv
// ----------------------------------------------------------------------------
// polyline_self_intersection_guard_top
// Vertex store of a polygon being drawn; judges each point against all edges.
// ----------------------------------------------------------------------------
// Sequence: an empty store goes straight to the result; otherwise the last vertex
//   is read, and the viewport, the single vertex or the last vertex may decide;
//   else all N stored vertices are read, one vertex per cycle, for the edge pipe.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result is loaded, and the finish state waits while an old result is unread.
// Reset: control, count and configuration registers return to defaults; the
//   vertex memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_self_intersection_guard_top #(
  parameter int MAX_VERTICES = psig_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [psig_pkg::IN_TDATA_W-1:0]    in_tdata,   // px[15:0], py[31:16]
  input  logic [psig_pkg::IN_TUSER_W-1:0]    in_tuser,   // cmd[1:0]
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_valid[0], closes_polygon[1], appended[2], store_full[3],
  // vertex_count[10:4], zero[15:11]
  output logic [psig_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration
  input  logic                               cfg_we,
  input  logic [psig_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [psig_pkg::CFG_W-1:0]         cfg_wdata
);
  import psig_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = VTX_W + 1;

  // configuration registers
  logic [CFG_W-1:0] view_w_r, view_h_r;
  logic [TOL_W-1:0] tol_x_r, tol_y_r;

  // control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   iss_idx_r, iss_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic            rd_first_r, rd_first_nxt;
  logic            hit_acc_r, hit_acc_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;

  // payload held for the current word
  cmd_t            cmd_r, cmd_nxt;
  vtx_t            pt_r, pt_nxt;
  vtx_t            first_r, first_nxt;
  vtx_t            last_r, last_nxt;
  vtx_t            prev_r, prev_nxt;
  logic            view_ok_r, view_ok_nxt;
  logic            box_ok_r, box_ok_nxt;
  logic            eq_first_r, eq_first_nxt;
  logic            eq_last_r, eq_last_nxt;
  logic            chk_ok_r, chk_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_closed_r, out_closed_nxt;
  logic            out_app_r, out_app_nxt;
  logic            out_full_r, out_full_nxt;
  logic [VCNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // vertex memory
  vtx_t            mem [MAX_VERTICES];
  vtx_t            rd_data_r;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  logic            mem_we;
  vtx_t            mem_wdata;

  // accept-side decode
  logic            in_acc;
  cmd_t            in_cmd;
  vtx_t            in_pt;
  logic [CW-1:0]   n_new;
  logic signed [DW-1:0] dx_s, dy_s;
  logic [DW-1:0]   dx_abs, dy_abs;

  // finish-side decode
  logic            fin_go, fin_valid, fin_closed, fast_done;

  edge_req_t       ereq;
  edge_res_t       eres;

  assign in_acc = in_tvalid && in_tready;
  assign in_cmd = cmd_t'(in_tuser);
  assign in_pt  = vtx_t'(in_tdata);
  assign fin_go = !out_tvalid_r || out_tready;

  always_comb begin
    case (in_cmd)
      CMD_CLEAR:  n_new = '0;
      CMD_REMOVE: n_new = (cnt_r > CW'(1)) ? cnt_r - CW'(1) : cnt_r;
      default:    n_new = cnt_r;
    endcase
  end

  // closing box distance to the first vertex
  always_comb begin
    dx_s   = DW'(in_pt.x) - DW'(first_r.x);
    dy_s   = DW'(in_pt.y) - DW'(first_r.y);
    dx_abs = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
    dy_abs = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
  end

  // fast decision once the last vertex is back from memory
  assign fast_done = !view_ok_r || (cnt_r == CW'(1)) || (rd_data_r == pt_r);

  // hand the stored edge (prev, current read) to the intersection pipe
  always_comb begin
    ereq.vld = (state_r == ST_SCAN) && rd_vld_r && !rd_first_r;
    ereq.a   = prev_r;
    ereq.b   = rd_data_r;
  end

  psig_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ereq),
    .pt    (pt_r),
    .lst   (last_r),
    .res   (eres)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (n_new == '0) ? ST_FINISH : ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = fast_done ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if ((iss_idx_r == cnt_r) && !rd_vld_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!eres.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt        = cnt_r;
    iss_idx_nxt    = iss_idx_r;
    rd_vld_nxt     = 1'b0;
    rd_first_nxt   = 1'b0;
    hit_acc_nxt    = hit_acc_r || (eres.vld && eres.hit);
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd_nxt        = cmd_r;
    pt_nxt         = pt_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    prev_nxt       = rd_vld_r ? rd_data_r : prev_r;
    view_ok_nxt    = view_ok_r;
    box_ok_nxt     = box_ok_r;
    eq_first_nxt   = eq_first_r;
    eq_last_nxt    = eq_last_r;
    chk_ok_nxt     = chk_ok_r;
    out_valid_nxt  = out_valid_r;
    out_closed_nxt = out_closed_r;
    out_app_nxt    = out_app_r;
    out_full_nxt   = out_full_r;
    out_cnt_nxt    = out_cnt_r;
    mem_raddr      = iss_idx_r[AW-1:0];
    mem_waddr      = cnt_r[AW-1:0];
    mem_we         = 1'b0;
    mem_wdata      = pt_r;
    in_tready      = (state_r == ST_IDLE);

    fin_valid  = chk_ok_r && !hit_acc_r;
    fin_closed = fin_valid && box_ok_r && (cnt_r != '0);

    case (state_r)
      ST_IDLE: begin
        // issue the read of the last vertex with the new count
        mem_raddr = AW'(n_new - CW'(1));
        if (in_acc) begin
          cnt_nxt      = n_new;
          cmd_nxt      = in_cmd;
          pt_nxt       = in_pt;
          hit_acc_nxt  = 1'b0;
          view_ok_nxt  = !in_pt.x[VTX_W-1] && !in_pt.y[VTX_W-1] &&
                         (in_pt.x[CFG_W-1:0] < view_w_r) &&
                         (in_pt.y[CFG_W-1:0] < view_h_r);
          box_ok_nxt   = (dx_abs <= DW'(tol_x_r)) && (dy_abs <= DW'(tol_y_r));
          eq_first_nxt = (in_pt == first_r);
          eq_last_nxt  = 1'b0;
          chk_ok_nxt   = !in_pt.x[VTX_W-1] && !in_pt.y[VTX_W-1] &&
                         (in_pt.x[CFG_W-1:0] < view_w_r) &&
                         (in_pt.y[CFG_W-1:0] < view_h_r);
        end
      end
      ST_LAST: begin
        last_nxt    = rd_data_r;
        eq_last_nxt = (rd_data_r == pt_r);
        chk_ok_nxt  = view_ok_r && !((cnt_r == CW'(1)) && eq_first_r);
        iss_idx_nxt = '0;
      end
      ST_SCAN: begin
        // one vertex read per cycle, edges stream out behind them
        if (iss_idx_r != cnt_r) begin
          rd_vld_nxt   = 1'b1;
          rd_first_nxt = (iss_idx_r == '0);
          iss_idx_nxt  = iss_idx_r + CW'(1);
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          out_tvalid_nxt = 1'b1;
          out_valid_nxt  = fin_valid;
          out_closed_nxt = fin_closed;
          out_app_nxt    = 1'b0;
          out_full_nxt   = 1'b0;
          if (cmd_r == CMD_APPEND) begin
            if (cnt_r == '0) begin
              mem_we      = 1'b1;
              mem_waddr   = '0;
              first_nxt   = pt_r;
              cnt_nxt     = CW'(1);
              out_app_nxt = 1'b1;
            end else if (fin_valid && !fin_closed && !eq_last_r) begin
              if (cnt_r >= CW'(MAX_VERTICES)) begin
                out_full_nxt = 1'b1;
              end else begin
                mem_we      = 1'b1;
                cnt_nxt     = cnt_r + CW'(1);
                out_app_nxt = 1'b1;
              end
            end
          end
          out_cnt_nxt = VCNT_W'(cnt_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  // vertex memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      iss_idx_r    <= '0;
      rd_vld_r     <= 1'b0;
      rd_first_r   <= 1'b0;
      hit_acc_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      iss_idx_r    <= iss_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_first_r   <= rd_first_nxt;
      hit_acc_r    <= hit_acc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pt_r         <= pt_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    prev_r       <= prev_nxt;
    view_ok_r    <= view_ok_nxt;
    box_ok_r     <= box_ok_nxt;
    eq_first_r   <= eq_first_nxt;
    eq_last_r    <= eq_last_nxt;
    chk_ok_r     <= chk_ok_nxt;
    out_valid_r  <= out_valid_nxt;
    out_closed_r <= out_closed_nxt;
    out_app_r    <= out_app_nxt;
    out_full_r   <= out_full_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r <= VIEW_W_RST;
      view_h_r <= VIEW_H_RST;
      tol_x_r  <= TOL_RST;
      tol_y_r  <= TOL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VIEW_W: view_w_r <= cfg_wdata;
        CFG_VIEW_H: view_h_r <= cfg_wdata;
        CFG_TOL_X:  tol_x_r  <= cfg_wdata[TOL_W-1:0];
        CFG_TOL_Y:  tol_y_r  <= cfg_wdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_cnt_r, out_full_r, out_app_r,
                                    out_closed_r, out_valid_r});

  `PSIG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE, "not idle after reset")
  `PSIG_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_VERTICES), "vertex count beyond store size")
  `PSIG_ASSERT(a_app_full, out_tvalid_r |-> !(out_app_r && out_full_r), "append and full both set")
  `PSIG_ASSERT(a_close_valid, out_tvalid_r && out_closed_r |-> out_valid_r, "closed without valid")
  `PSIG_ASSERT(a_idle_quiet, state_r == ST_IDLE |-> !eres.busy, "edge pipe busy while idle")

endmodule
